FILE: rtl/gdd_pkg.sv
package gdd_pkg;

    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 6;
    localparam int DOY_W    = 9;
    localparam int DBY_W    = 23;
    localparam int DIFF_W   = 23;
    localparam int DIFF_X_W = 25;
    localparam int QUOT_W   = 8;
    localparam int MLEN_W   = 5;
    localparam int CMP_W    = 17;

    // y / 100 == (y * 5243) >> 19 for every 14-bit y
    localparam int RECIP_100   = 5243;
    localparam int RECIP_SHIFT = 19;
    localparam int PROD_W      = YEAR_W + 13;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    localparam logic [MLEN_W-1:0]  FEB_LEAP_LEN   = 5'd29;
    localparam logic [DOY_W-1:0]   DAYS_YEAR      = 9'd365;
    localparam logic [DOY_W-1:0]   DAYS_LEAP_YEAR = 9'd366;
    localparam logic [YEAR_W-1:0]  CENTURY        = 14'd100;

    localparam logic signed [DIFF_X_W-1:0] DIFF_MAX = 25'sd4194303;
    localparam logic signed [DIFF_X_W-1:0] DIFF_MIN = -25'sd4194304;

    typedef logic [YEAR_W-1:0]  year_t;
    typedef logic [MONTH_W-1:0] month_t;
    typedef logic [DAY_W-1:0]   day_t;
    typedef logic [DOY_W-1:0]   doy_t;
    typedef logic [DBY_W-1:0]   dby_t;
    typedef logic [QUOT_W-1:0]  quot_t;

    function automatic logic [MLEN_W-1:0] month_len(input month_t m);
        logic [MLEN_W-1:0] len;
        unique case (m)
            4'd2:                      len = 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

    function automatic doy_t days_before_month(input month_t m);
        doy_t dbm;
        unique case (m)
            4'd2:    dbm = 9'd31;
            4'd3:    dbm = 9'd59;
            4'd4:    dbm = 9'd90;
            4'd5:    dbm = 9'd120;
            4'd6:    dbm = 9'd151;
            4'd7:    dbm = 9'd181;
            4'd8:    dbm = 9'd212;
            4'd9:    dbm = 9'd243;
            4'd10:   dbm = 9'd273;
            4'd11:   dbm = 9'd304;
            4'd12:   dbm = 9'd334;
            default: dbm = 9'd0;
        endcase
        return dbm;
    endfunction

endpackage

FILE: rtl/gregorian_day_difference_top.sv
// Gregorian date difference. Each transaction carries a start and an end date;
// months outside 1..12 and invalid days are taken as 1, years above MAX_YEAR
// are clamped, and leap years follow the 4/100/400 rule (year 0 is leap).
// The result gives the signed day count from start to end (saturated to 23
// bits), the day of year of both dates and the days left in the start year.
// Five register stages (clamp, divide by 100, day-of-year and day count, difference,
// saturation/output): one transaction is taken every cycle while the output is not stalled,
// and back-pressure on m_tready stalls the pipeline without losing data.
module gregorian_day_difference_top #(
    parameter int MAX_YEAR = 9999
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // start_year, start_month, start_day, end_year, end_month, end_day
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // days_between, start_day_of_year, end_day_of_year, start_days_left, pad
    output logic [55:0] m_tdata
);

    localparam int STAGES = 5;

    logic [STAGES-1:0] v_reg, v_next;
    logic [STAGES-1:0] en;

    gdd_pkg::doy_t s_doy, e_doy;
    gdd_pkg::dby_t s_dby, e_dby;
    logic          s_leap, e_leap;

    logic signed [gdd_pkg::DIFF_X_W-1:0] diff4_reg, diff4_next;
    gdd_pkg::doy_t sdoy4_reg, edoy4_reg, left4_reg, left4_next;

    logic [gdd_pkg::DIFF_W-1:0] diff5_reg, diff5_next;
    gdd_pkg::doy_t sdoy5_reg, edoy5_reg, left5_reg;

    always_comb begin
        en[STAGES-1] = !v_reg[STAGES-1] || m_tready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            en[k] = !v_reg[k] || en[k+1];
        end
        v_next[0] = en[0] ? s_tvalid : v_reg[0];
        for (int k = 1; k < STAGES; k++) begin
            v_next[k] = en[k] ? v_reg[k-1] : v_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= v_next;
        end
    end

    assign s_tready = en[0];
    assign m_tvalid = v_reg[STAGES-1];

    gdd_date #(.MAX_YEAR(MAX_YEAR)) u_start (
        .aclk  (aclk),
        .adv   (en[2:0]),
        .year  (s_tdata[13:0]),
        .month (s_tdata[17:14]),
        .day   (s_tdata[23:18]),
        .doy   (s_doy),
        .dby   (s_dby),
        .leap  (s_leap)
    );

    gdd_date #(.MAX_YEAR(MAX_YEAR)) u_end (
        .aclk  (aclk),
        .adv   (en[2:0]),
        .year  (s_tdata[37:24]),
        .month (s_tdata[41:38]),
        .day   (s_tdata[47:42]),
        .doy   (e_doy),
        .dby   (e_dby),
        .leap  (e_leap)
    );

    always_comb begin
        diff4_next = $signed(gdd_pkg::DIFF_X_W'(e_dby)) - $signed(gdd_pkg::DIFF_X_W'(s_dby))
                   + $signed(gdd_pkg::DIFF_X_W'(e_doy)) - $signed(gdd_pkg::DIFF_X_W'(s_doy));
        left4_next = (s_leap ? gdd_pkg::DAYS_LEAP_YEAR : gdd_pkg::DAYS_YEAR) - s_doy;
    end

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            diff4_reg <= diff4_next;
            sdoy4_reg <= s_doy;
            edoy4_reg <= e_doy;
            left4_reg <= left4_next;
        end
    end

    always_comb begin
        priority if (diff4_reg > gdd_pkg::DIFF_MAX) begin
            diff5_next = gdd_pkg::DIFF_W'(gdd_pkg::DIFF_MAX);
        end else if (diff4_reg < gdd_pkg::DIFF_MIN) begin
            diff5_next = gdd_pkg::DIFF_W'(gdd_pkg::DIFF_MIN);
        end else begin
            diff5_next = diff4_reg[gdd_pkg::DIFF_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en[4]) begin
            diff5_reg <= diff5_next;
            sdoy5_reg <= sdoy4_reg;
            edoy5_reg <= edoy4_reg;
            left5_reg <= left4_reg;
        end
    end

    assign m_tdata = {6'd0, left5_reg, edoy5_reg, sdoy5_reg, diff5_reg};

`ifndef NO_ASSERTIONS
    a_full_when_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (&v_reg))
        else $error("input blocked while pipeline has a bubble");

    a_year_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((10'(left5_reg) + 10'(sdoy5_reg) == 10'd365) ||
                      (10'(left5_reg) + 10'(sdoy5_reg) == 10'd366)))
        else $error("days left and day of year do not make a year");

    a_doy_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (sdoy5_reg != '0 && sdoy5_reg <= gdd_pkg::DAYS_LEAP_YEAR &&
                      edoy5_reg != '0 && edoy5_reg <= gdd_pkg::DAYS_LEAP_YEAR))
        else $error("day of year out of range");

    a_last_day_leap: assert property (@(posedge aclk) disable iff (!aresetn)
        v_reg[2] |-> ((e_leap || e_doy != gdd_pkg::DAYS_LEAP_YEAR) &&
                      (s_leap || s_doy != gdd_pkg::DAYS_LEAP_YEAR)))
        else $error("day 366 in a common year");

    a_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (v_reg[0] && en[1]) |=> v_reg[1])
        else $error("transaction lost between stage 1 and 2");
`endif

endmodule

FILE: rtl/gdd_date.sv
module gdd_date #(
    parameter int MAX_YEAR = 9999
) (
    input  logic                 aclk,
    input  logic [2:0]           adv,
    input  gdd_pkg::year_t       year,
    input  gdd_pkg::month_t      month,
    input  gdd_pkg::day_t        day,
    output gdd_pkg::doy_t        doy,
    output gdd_pkg::dby_t        dby,
    output logic                 leap
);

    // stage 1: clamp year, fix month
    gdd_pkg::year_t  yr1_reg, yr1_next;
    gdd_pkg::year_t  p1_reg, p1_next;
    logic            zero1_reg;
    gdd_pkg::month_t mon1_reg, mon1_next;
    gdd_pkg::day_t   day1_reg;

    // stage 2: divide by 100
    gdd_pkg::year_t  yr2_reg, p2_reg;
    logic            zero2_reg;
    gdd_pkg::month_t mon2_reg;
    gdd_pkg::day_t   day2_reg;
    gdd_pkg::quot_t  qy2_reg, qy2_next, qp2_reg, qp2_next;
    logic [gdd_pkg::PROD_W-1:0] prod_y, prod_p;

    // stage 3: leap, day of year, days before year
    gdd_pkg::doy_t   doy3_reg, doy3_next;
    gdd_pkg::dby_t   dby3_reg, dby3_next;
    logic            leap3_reg, leap3_next;
    gdd_pkg::year_t  rem100;
    logic [gdd_pkg::MLEN_W-1:0] lim;
    gdd_pkg::day_t   day_ok;

    always_comb begin
        yr1_next = ({{(gdd_pkg::CMP_W - gdd_pkg::YEAR_W){1'b0}}, year}
                    > gdd_pkg::CMP_W'(MAX_YEAR)) ? gdd_pkg::YEAR_W'(MAX_YEAR) : year;
        p1_next  = yr1_next - gdd_pkg::YEAR_W'(1);
        mon1_next = (month >= gdd_pkg::MONTH_JAN && month <= gdd_pkg::MONTH_DEC)
                    ? month : gdd_pkg::MONTH_JAN;
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            yr1_reg   <= yr1_next;
            p1_reg    <= p1_next;
            zero1_reg <= (yr1_next == '0);
            mon1_reg  <= mon1_next;
            day1_reg  <= day;
        end
    end

    always_comb begin
        prod_y   = gdd_pkg::PROD_W'(yr1_reg) * gdd_pkg::PROD_W'(gdd_pkg::RECIP_100);
        prod_p   = gdd_pkg::PROD_W'(p1_reg) * gdd_pkg::PROD_W'(gdd_pkg::RECIP_100);
        qy2_next = gdd_pkg::QUOT_W'(prod_y >> gdd_pkg::RECIP_SHIFT);
        qp2_next = gdd_pkg::QUOT_W'(prod_p >> gdd_pkg::RECIP_SHIFT);
    end

    always_ff @(posedge aclk) begin
        if (adv[1]) begin
            yr2_reg   <= yr1_reg;
            p2_reg    <= p1_reg;
            zero2_reg <= zero1_reg;
            mon2_reg  <= mon1_reg;
            day2_reg  <= day1_reg;
            qy2_reg   <= qy2_next;
            qp2_reg   <= qp2_next;
        end
    end

    always_comb begin
        rem100     = yr2_reg - gdd_pkg::YEAR_W'(gdd_pkg::YEAR_W'(qy2_reg) * gdd_pkg::CENTURY);
        leap3_next = (yr2_reg[1:0] == 2'b00) && ((rem100 != '0) || (qy2_reg[1:0] == 2'b00));
        lim        = (mon2_reg == gdd_pkg::MONTH_FEB && leap3_next)
                     ? gdd_pkg::FEB_LEAP_LEN : gdd_pkg::month_len(mon2_reg);
        day_ok     = (day2_reg != '0 && day2_reg <= gdd_pkg::DAY_W'(lim))
                     ? day2_reg : gdd_pkg::DAY_W'(1);
        doy3_next  = gdd_pkg::days_before_month(mon2_reg) + gdd_pkg::DOY_W'(day_ok)
                     + gdd_pkg::DOY_W'(mon2_reg > gdd_pkg::MONTH_FEB && leap3_next);
        if (zero2_reg) begin
            dby3_next = '0;
        end else begin
            dby3_next = gdd_pkg::DBY_W'(yr2_reg) * gdd_pkg::DBY_W'(gdd_pkg::DAYS_YEAR)
                      + gdd_pkg::DBY_W'(p2_reg >> 2)
                      - gdd_pkg::DBY_W'(qp2_reg)
                      + gdd_pkg::DBY_W'(qp2_reg >> 2)
                      + gdd_pkg::DBY_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[2]) begin
            doy3_reg  <= doy3_next;
            dby3_reg  <= dby3_next;
            leap3_reg <= leap3_next;
        end
    end

    assign doy  = doy3_reg;
    assign dby  = dby3_reg;
    assign leap = leap3_reg;

endmodule

FILE: tb/sv/gregorian_day_difference_checker.sv
`timescale 1ns / 1ps

module gregorian_day_difference_checker #(
    parameter int MAX_YEAR = 9999
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [55:0] m_tdata,
    output int          errors,
    output int          pending
);

    typedef struct {
        logic signed [gdd_pkg::DIFF_W-1:0] days_between;
        gdd_pkg::doy_t                     start_doy;
        gdd_pkg::doy_t                     end_doy;
        gdd_pkg::doy_t                     start_left;
    } day_diff_t;

    localparam int MONTH_DAYS[13]  = '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    localparam int MONTH_START[13] = '{0, 0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
    localparam int SAT_HI = 4194303;
    localparam int SAT_LO = -4194304;

    day_diff_t diff_q[$];

    function automatic bit leap_year(input int y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    // days in years 0 .. y-1, year 0 leap
    function automatic int days_to_year(input int y);
        int p;
        if (y == 0) begin
            return 0;
        end
        p = y - 1;
        return 365 * y + p / 4 - p / 100 + p / 400 + 1;
    endfunction

    function automatic int ordinal_day(input int y, input gdd_pkg::month_t m_in,
                                       input gdd_pkg::day_t d_in);
        int m;
        int lim;
        int d;
        int n;
        m = (m_in >= 1 && m_in <= 12) ? int'(m_in) : 1;
        lim = MONTH_DAYS[m];
        if (m == 2 && leap_year(y)) begin
            lim = 29;
        end
        d = (d_in >= 1 && d_in <= lim) ? int'(d_in) : 1;
        n = MONTH_START[m] + d;
        if (m > 2 && leap_year(y)) begin
            n++;
        end
        return n;
    endfunction

    function automatic day_diff_t predict_day_diff(input logic [47:0] d);
        gdd_pkg::year_t sy_in;
        gdd_pkg::year_t ey_in;
        int             sy;
        int             ey;
        int             sdoy;
        int             edoy;
        int             span;
        int             left;
        day_diff_t      r;
        sy_in = d[13:0];
        ey_in = d[37:24];
        sy = (sy_in > MAX_YEAR) ? MAX_YEAR : int'(sy_in);
        ey = (ey_in > MAX_YEAR) ? MAX_YEAR : int'(ey_in);
        sdoy = ordinal_day(sy, d[17:14], d[23:18]);
        edoy = ordinal_day(ey, d[41:38], d[47:42]);
        span = days_to_year(ey) - days_to_year(sy) + edoy - sdoy;
        if (span > SAT_HI) begin
            span = SAT_HI;
        end
        if (span < SAT_LO) begin
            span = SAT_LO;
        end
        left = leap_year(sy) ? 366 - sdoy : 365 - sdoy;
        r.days_between = span[gdd_pkg::DIFF_W-1:0];
        r.start_doy    = sdoy[gdd_pkg::DOY_W-1:0];
        r.end_doy      = edoy[gdd_pkg::DOY_W-1:0];
        r.start_left   = left[gdd_pkg::DOY_W-1:0];
        return r;
    endfunction

    always @(posedge aclk) begin
        day_diff_t exp_r;
        day_diff_t got;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                diff_q.push_back(predict_day_diff(s_tdata));
            end
            if (m_tvalid && m_tready) begin
                got.days_between = m_tdata[22:0];
                got.start_doy    = m_tdata[31:23];
                got.end_doy      = m_tdata[40:32];
                got.start_left   = m_tdata[49:41];
                if (diff_q.size() == 0) begin
                    $error("unexpected result transaction: tdata %h", m_tdata);
                    errors++;
                end else begin
                    exp_r = diff_q.pop_front();
                    if (got.days_between !== exp_r.days_between) begin
                        $error("days_between expected %0d got %0d",
                               exp_r.days_between, got.days_between);
                        errors++;
                    end
                    if (got.start_doy !== exp_r.start_doy) begin
                        $error("start_day_of_year expected %0d got %0d",
                               exp_r.start_doy, got.start_doy);
                        errors++;
                    end
                    if (got.end_doy !== exp_r.end_doy) begin
                        $error("end_day_of_year expected %0d got %0d",
                               exp_r.end_doy, got.end_doy);
                        errors++;
                    end
                    if (got.start_left !== exp_r.start_left) begin
                        $error("start_days_left expected %0d got %0d",
                               exp_r.start_left, got.start_left);
                        errors++;
                    end
                end
            end
        end
        pending = diff_q.size();
    end

endmodule

FILE: tb/sv/gregorian_day_difference_top_tb.sv
`timescale 1ns / 1ps

module gregorian_day_difference_top_tb;

    localparam int MAX_YEAR    = 9999;
    localparam int N_RANDOM    = 630;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN       = 20;

    localparam int MONTH_DAYS[13] = '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic        no_idle  = 1'b0;
    int          errors;
    int          pending;
    int          cycles   = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    gregorian_day_difference_top #(.MAX_YEAR(MAX_YEAR)) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    gregorian_day_difference_checker #(.MAX_YEAR(MAX_YEAR)) u_checker (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .errors   (errors),
        .pending  (pending)
    );

    always @(posedge aclk) begin
        m_tready <= no_idle || ($urandom_range(0, 99) >= 36);
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic logic [47:0] pack_dates(input gdd_pkg::year_t sy,
                                               input gdd_pkg::month_t sm,
                                               input gdd_pkg::day_t sd,
                                               input gdd_pkg::year_t ey,
                                               input gdd_pkg::month_t em,
                                               input gdd_pkg::day_t ed);
        return {ed, em, ey, sd, sm, sy};
    endfunction

    // well-formed date fields {day, month, year}
    function automatic logic [23:0] valid_date(input int y);
        int m;
        int lim;
        m = $urandom_range(1, 12);
        lim = MONTH_DAYS[m];
        if (m == 2 && (((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0))) begin
            lim = 29;
        end
        return {gdd_pkg::day_t'($urandom_range(1, lim)), gdd_pkg::month_t'(m),
                gdd_pkg::year_t'(y)};
    endfunction

    task automatic send_dates(input logic [47:0] d);
        while (!no_idle && $urandom_range(0, 99) < 36) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (pending != 0);
        @(posedge aclk);
    endtask

    initial begin
        logic [23:0] a;
        logic [23:0] b;
        int          sel;
        int          y0;
        int          y1;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_dates(pack_dates(14'd0, 4'd1, 6'd1, 14'd9999, 4'd12, 6'd31));
        send_dates(pack_dates(14'd9999, 4'd12, 6'd31, 14'd0, 4'd1, 6'd1));
        send_dates(pack_dates(14'd16383, 4'd15, 6'd63, 14'd10000, 4'd0, 6'd0));
        send_dates('0);
        send_dates('1);
        send_dates(pack_dates(14'd2000, 4'd2, 6'd29, 14'd1900, 4'd2, 6'd29));
        send_dates(pack_dates(14'd2023, 4'd2, 6'd29, 14'd2024, 4'd2, 6'd29));
        send_dates(pack_dates(14'd2020, 4'd12, 6'd31, 14'd2021, 4'd12, 6'd31));
        send_dates(pack_dates(14'd0, 4'd3, 6'd1, 14'd400, 4'd3, 6'd1));
        send_dates(pack_dates(14'd100, 4'd3, 6'd1, 14'd200, 4'd2, 6'd28));
        send_dates(pack_dates(14'd1999, 4'd13, 6'd15, 14'd1999, 4'd14, 6'd20));
        send_dates(pack_dates(14'd2010, 4'd4, 6'd31, 14'd2010, 4'd4, 6'd30));
        send_dates(pack_dates(14'd2010, 4'd6, 6'd0, 14'd2010, 4'd7, 6'd32));
        send_dates(pack_dates(14'd1600, 4'd11, 6'd30, 14'd1600, 4'd11, 6'd30));
        send_dates(pack_dates(14'd9999, 4'd2, 6'd28, 14'd12000, 4'd2, 6'd29));
        send_dates(pack_dates(14'd10000, 4'd8, 6'd31, 14'd9998, 4'd9, 6'd31));
        send_dates(pack_dates(14'd1, 4'd1, 6'd31, 14'd0, 4'd12, 6'd31));
        send_dates(pack_dates(14'd4, 4'd10, 6'd31, 14'd8192, 4'd5, 6'd31));
        send_dates(pack_dates(14'd5461, 4'd10, 6'd42, 14'd10922, 4'd5, 6'd21));

        // let the pipeline run empty before the random part
        wait_drained();

        for (int i = 0; i < N_RANDOM; i++) begin
            no_idle <= (i >= 200 && i < 320);
            sel = $urandom_range(0, 99);
            if (sel < 15) begin
                send_dates(48'($urandom()) | (48'($urandom()) << 32));
            end else begin
                y0 = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 16383)
                                                 : $urandom_range(0, MAX_YEAR);
                if (sel < 45) begin
                    y1 = y0 + $urandom_range(0, 4) - 2;
                    if (y1 < 0) begin
                        y1 = 0;
                    end
                end else begin
                    y1 = $urandom_range(0, MAX_YEAR);
                end
                a = valid_date(y0);
                b = valid_date(y1);
                if (sel >= 90) begin
                    a[17:14] = gdd_pkg::month_t'($urandom_range(0, 15));
                    b[23:18] = gdd_pkg::day_t'($urandom_range(0, 63));
                end
                send_dates({b, a});
            end
        end

        wait_drained();
        repeat (DRAIN) @(posedge aclk);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/gdd_pkg.sv
rtl/gdd_date.sv
rtl/gregorian_day_difference_top.sv
tb/sv/gregorian_day_difference_checker.sv
tb/sv/gregorian_day_difference_top_tb.sv
